// ----- rtl/assert_macros.svh -----
// Assertion macros; the bodies are empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define MFD_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed: %m")

`define MFD_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("assertion failed: %m")

`else

`define MFD_ASSERT(name, prop)

`define MFD_ASSERT_ALWAYS(name, prop)

`endif

`endif

// ----- rtl/mfd_pkg.sv -----
package mfd_pkg;

  localparam int unsigned BYTE_W    = 7;
  localparam int unsigned DIGIT_W   = 8;
  localparam int unsigned MAG_W     = 22;
  localparam int unsigned FACTOR_W  = 23;
  localparam int unsigned PROD_W    = MAG_W + FACTOR_W;
  localparam int unsigned READING_W = 40;
  localparam int unsigned NUM_DIGITS = 5;
  localparam int unsigned FIFO_DEPTH = 4;

  localparam logic [BYTE_W-1:0]  LINE_FEED  = 7'h0A;
  localparam logic [DIGIT_W-1:0] ASCII_ZERO = 8'h30;
  localparam logic [BYTE_W-1:0]  NEG_MASK   = 7'h04;

  // Reciprocal constants: floor(n * M / 2^S) == floor(n / d) for n < 2^MAG_W
  localparam logic [FACTOR_W-1:0] RECIP_10  = 23'd6710887;
  localparam int unsigned         SHIFT_10  = 26;
  localparam logic [FACTOR_W-1:0] RECIP_100 = 23'd5368710;
  localparam int unsigned         SHIFT_100 = 29;

  typedef enum logic [1:0] {
    REG_VOLTAGE  = 2'd0,
    REG_MICROAMP = 2'd1,
    REG_MILLIAMP = 2'd2,
    REG_AMP      = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    SC_X1,
    SC_X10,
    SC_X100,
    SC_X1000,
    SC_X10000,
    SC_X100000,
    SC_DIV10,
    SC_DIV100
  } scale_e;

  typedef struct packed {
    logic [BYTE_W-1:0] voltage;
    logic [BYTE_W-1:0] microamp;
    logic [BYTE_W-1:0] milliamp;
    logic [BYTE_W-1:0] amp;
  } cfg_t;

  typedef struct packed {
    logic [NUM_DIGITS-1:0][BYTE_W-1:0] digits;
    logic [BYTE_W-1:0]                 range_byte;
    logic [BYTE_W-1:0]                 func;
    logic                              neg;
    logic                              auto_range;
    logic                              dc_mode;
  } frame_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  localparam logic [NUM_DIGITS-1:0][MAG_W-1:0] DIGIT_WEIGHT = {
    22'd1, 22'd10, 22'd100, 22'd1000, 22'd10000
  };

  function automatic logic [DIGIT_W-1:0] digit_of(input logic [BYTE_W-1:0] b);
    return {1'b0, b} - ASCII_ZERO;
  endfunction

  function automatic logic [FACTOR_W-1:0] factor_of(input scale_e sc);
    logic [FACTOR_W-1:0] f;
    case (sc)
      SC_X10:     f = 23'd10;
      SC_X100:    f = 23'd100;
      SC_X1000:   f = 23'd1000;
      SC_X10000:  f = 23'd10000;
      SC_X100000: f = 23'd100000;
      SC_DIV10:   f = RECIP_10;
      SC_DIV100:  f = RECIP_100;
      default:    f = 23'd1;
    endcase
    return f;
  endfunction

endpackage

// ----- rtl/mfd_front.sv -----
module mfd_front #(
  parameter int unsigned FRAME_BYTES = 13
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic [mfd_pkg::BYTE_W-1:0]   in_byte_i,
  output logic                         in_ready_o,
  input  mfd_pkg::fifo_stat_t          fifo_stat_i,
  output logic                         push_o,
  output mfd_pkg::frame_t              frame_o
);
  import mfd_pkg::*;

  localparam int unsigned CNT_W = $clog2(FRAME_BYTES + 2);

  logic [BYTE_W-1:0] buf_q [FRAME_BYTES];
  logic [CNT_W-1:0]  cnt_d, cnt_q;
  logic              accept, is_lf;

  assign in_ready_o = !fifo_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign is_lf      = (in_byte_i == LINE_FEED);

  for (genvar i = 0; i < FRAME_BYTES; i++) begin : g_buf
    always_ff @(posedge clk_i) begin
      if (accept && !is_lf && (cnt_q == CNT_W'(i))) begin
        buf_q[i] <= in_byte_i;
      end
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (accept) begin
      if (is_lf) begin
        cnt_d = '0;
      end else if (cnt_q < CNT_W'(FRAME_BYTES + 1)) begin
        cnt_d = cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign push_o = accept && is_lf && (cnt_q == CNT_W'(FRAME_BYTES));

  always_comb begin
    for (int k = 0; k < NUM_DIGITS; k++) begin
      frame_o.digits[k] = buf_q[k + 1];
    end
    frame_o.range_byte = buf_q[0];
    frame_o.func       = buf_q[6];
    frame_o.neg        = |(buf_q[7] & NEG_MASK);
    frame_o.auto_range = buf_q[10][1];
    frame_o.dc_mode    = buf_q[10][3];
  end

endmodule

// ----- rtl/mfd_fifo.sv -----
module mfd_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  mfd_pkg::frame_t     wdata_i,
  input  logic                pop_i,
  output mfd_pkg::frame_t     rdata_o,
  output mfd_pkg::fifo_stat_t stat_o
);
  import mfd_pkg::*;

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  frame_t           mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wptr_d, wptr_q, rptr_d, rptr_q;
  logic [CNT_W-1:0] cnt_d, cnt_q;
  logic             do_push, do_pop;

  assign stat_o.full  = (cnt_q == CNT_W'(FIFO_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign rdata_o      = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_comb begin
    wptr_d = do_push ? wptr_q + PTR_W'(1) : wptr_q;
    rptr_d = do_pop  ? rptr_q + PTR_W'(1) : rptr_q;
    cnt_d  = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// ----- rtl/mfd_back.sv -----
module mfd_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mfd_pkg::cfg_t                 cfg_i,
  input  logic                          in_valid_i,
  input  mfd_pkg::frame_t               frame_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mfd_pkg::READING_W-1:0] reading_o,
  output logic [mfd_pkg::BYTE_W-1:0]    func_o,
  output logic                          auto_range_o,
  output logic                          dc_mode_o
);
  import mfd_pkg::*;

  typedef struct packed {
    scale_e            sc;
    logic              neg;
    logic [BYTE_W-1:0] func;
    logic              auto_range;
    logic              dc_mode;
  } tag_t;

  logic               adv;
  logic               s1_valid_q, s2_valid_q, out_valid_q;
  logic [MAG_W-1:0]   mag_d, mag_q;
  logic [PROD_W-1:0]  prod_q;
  tag_t               tag_d, s1_tag_q, s2_tag_q;
  logic [DIGIT_W-1:0] rng;
  logic [PROD_W-1:0]  shifted;
  logic [READING_W-1:0] scaled, reading_q;
  logic [BYTE_W-1:0]  func_q;
  logic               auto_q, dc_q;

  assign adv   = !out_valid_q || out_ready_i;
  assign pop_o = adv && in_valid_i;

  always_comb begin
    mag_d = '0;
    for (int k = 0; k < NUM_DIGITS; k++) begin
      mag_d = mag_d + MAG_W'(digit_of(frame_i.digits[k])) * DIGIT_WEIGHT[k];
    end
  end

  always_comb begin
    rng            = digit_of(frame_i.range_byte);
    tag_d.sc       = SC_X1;
    tag_d.neg      = frame_i.neg;
    tag_d.func     = frame_i.func;
    tag_d.auto_range = frame_i.auto_range;
    tag_d.dc_mode  = frame_i.dc_mode;
    if (frame_i.func == cfg_i.voltage) begin
      case (rng)
        8'd0:    tag_d.sc = SC_X100;
        8'd1:    tag_d.sc = SC_X1000;
        8'd2:    tag_d.sc = SC_X10000;
        8'd3:    tag_d.sc = SC_X100000;
        8'd4:    tag_d.sc = SC_X10;
        default: tag_d.sc = SC_X1;
      endcase
    end else if (frame_i.func == cfg_i.microamp) begin
      case (rng)
        8'd0:    tag_d.sc = SC_DIV100;
        8'd1:    tag_d.sc = SC_DIV10;
        default: tag_d.sc = SC_X1;
      endcase
    end else if (frame_i.func == cfg_i.milliamp) begin
      tag_d.sc = (rng == 8'd1) ? SC_X10 : SC_X1;
    end else if (frame_i.func == cfg_i.amp) begin
      tag_d.sc = SC_X1000;
    end
  end

  always_comb begin
    case (s2_tag_q.sc)
      SC_DIV10:  shifted = prod_q >> SHIFT_10;
      SC_DIV100: shifted = prod_q >> SHIFT_100;
      default:   shifted = prod_q;
    endcase
    scaled = shifted[READING_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mag_q     <= mag_d;
      s1_tag_q  <= tag_d;
      prod_q    <= PROD_W'(mag_q) * PROD_W'(factor_of(s1_tag_q.sc));
      s2_tag_q  <= s1_tag_q;
      reading_q <= s2_tag_q.neg ? (~scaled + READING_W'(1)) : scaled;
      func_q    <= s2_tag_q.func;
      auto_q    <= s2_tag_q.auto_range;
      dc_q      <= s2_tag_q.dc_mode;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= in_valid_i;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign reading_o    = reading_q;
  assign func_o       = func_q;
  assign auto_range_o = auto_q;
  assign dc_mode_o    = dc_q;

endmodule

// ----- rtl/multimeter_frame_decoder_core.sv -----
// Throughput: one byte per cycle while the frame queue is not full; one reading per
// frame of FRAME_BYTES + 1 bytes. A reading passes queue write, digit sum, scale
// multiply and output register in turn after the closing line feed is taken.
// A 4-entry frame queue between byte intake and scaling absorbs output stalls.
// Reset (rst_ni low, asynchronous) clears byte count, queue and pipeline valids
// and loads the default function codes; frame bytes are not cleared.
`include "assert_macros.svh"

module multimeter_frame_decoder_core #(
  parameter int unsigned FRAME_BYTES = 13
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [7:0]                         s_axis_tdata,   // [7:0] rx_byte
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [mfd_pkg::READING_W-1:0]      m_axis_tdata,   // [39:0] reading
  output logic [15:0]                        m_axis_tuser,   // [6:0] function_byte,
                                                             // [7] auto_range, [8] dc_mode
  input  logic                               cfg_we_i,
  input  logic [1:0]                         cfg_idx_i,
  input  logic [mfd_pkg::BYTE_W-1:0]         cfg_data_i
);
  import mfd_pkg::*;

  cfg_t              cfg_q;
  fifo_stat_t        fifo_stat;
  frame_t            push_frame, pop_frame;
  logic              push, pop;
  logic [BYTE_W-1:0] func;
  logic              auto_range, dc_mode;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.voltage  <= 7'd59;
      cfg_q.microamp <= 7'd61;
      cfg_q.milliamp <= 7'd63;
      cfg_q.amp      <= 7'd48;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_VOLTAGE:  cfg_q.voltage  <= cfg_data_i;
        REG_MICROAMP: cfg_q.microamp <= cfg_data_i;
        REG_MILLIAMP: cfg_q.milliamp <= cfg_data_i;
        REG_AMP:      cfg_q.amp      <= cfg_data_i;
        default:      cfg_q          <= cfg_q;
      endcase
    end
  end

  mfd_front #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_byte_i   (s_axis_tdata[BYTE_W-1:0]),
    .in_ready_o  (s_axis_tready),
    .fifo_stat_i (fifo_stat),
    .push_o      (push),
    .frame_o     (push_frame)
  );

  mfd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_frame),
    .pop_i   (pop),
    .rdata_o (pop_frame),
    .stat_o  (fifo_stat)
  );

  mfd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (!fifo_stat.empty),
    .frame_i      (pop_frame),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .reading_o    (m_axis_tdata),
    .func_o       (func),
    .auto_range_o (auto_range),
    .dc_mode_o    (dc_mode)
  );

  assign m_axis_tuser = {7'd0, dc_mode, auto_range, func};

  `MFD_ASSERT(a_push_not_full, push |-> !fifo_stat.full);
  `MFD_ASSERT(a_pop_not_empty, pop |-> !fifo_stat.empty);
  `MFD_ASSERT(a_full_not_empty, fifo_stat.full |-> !fifo_stat.empty);
  `MFD_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> fifo_stat.empty && !m_axis_tvalid);

endmodule
